[rtl/ookprd_pkg.sv]
// Shared package for the OOK pulse repeat detector.
// Holds field widths, register and event codes, the mode encoding and the
// tolerance match function. Depends on nothing else.
package ookprd_pkg;

	localparam int DUR_W           = 16;
	localparam int MSG_LEN_W       = 8;
	localparam int CFG_IDX_W       = 3;
	localparam int DEFAULT_MAX_LEN = 128;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHORT_ON  = 3'd0,
		REG_SHORT_OFF = 3'd1,
		REG_LONG_ON   = 3'd2,
		REG_LONG_OFF  = 3'd3,
		REG_REST      = 3'd4,
		REG_TOLERANCE = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [DUR_W-1:0] short_on_time;
		logic [DUR_W-1:0] short_off_time;
		logic [DUR_W-1:0] long_on_time;
		logic [DUR_W-1:0] long_off_time;
		logic [DUR_W-1:0] rest_time;
		logic [DUR_W-1:0] tolerance;
	} cfg_t;

	// Detector mode, one-hot.
	typedef enum logic [3:0] {
		MODE_SEARCH  = 4'b0001,
		MODE_CAPTURE = 4'b0010,
		MODE_VERIFY  = 4'b0100,
		MODE_SKIP    = 4'b1000
	} mode_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_BEGIN = 2'd1,
		EV_STOP  = 2'd2
	} event_t;

	typedef struct packed {
		event_t                 event_res;
		logic                   receiving;
		logic [MSG_LEN_W-1:0]   message_length;
	} result_t;

	// True when the two durations differ by at most tol.
	function automatic logic near_value(input logic [DUR_W-1:0] actual,
			input logic [DUR_W-1:0] nominal, input logic [DUR_W-1:0] tol);
		logic [DUR_W-1:0] diff;
		diff = (actual > nominal) ? (actual - nominal) : (nominal - actual);
		return diff <= tol;
	endfunction

endpackage

[rtl/ook_pulse_repeat_detector_core.sv]
// Top level of the OOK pulse repeat detector: configuration registers, input
// register, result register. Depends on ookprd_pkg, ookprd_fsm, ookprd_ram.
//
// Usage:
// Each input transaction carries one measured pulse or gap duration on
// duration with in_valid; it is taken at a clock edge where in_stall is low.
// Every input transaction yields exactly one output transaction carrying
// event_res (none, begin, stop), receiving and message_length.
// The duration lands in an input register, is classified from there, and
// the result is held in an output register until out_stall is low.
// Throughput is one transaction per cycle while the receiver does not stall;
// the only serial dependence is the mode and counter update in the sequencer,
// and the stored symbol for the next verify step is prefetched from the RAM.
// When the receiver stalls, the result register holds, the input register
// fills, and in_stall rises only when both are occupied.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) are to be made by the
// user while the block is idle; the block itself does not enforce this. Indexes
// past the tolerance register are ignored. Reset clears the configuration and
// control registers and puts the sequencer in search mode. The symbol store
// needs no clearing: verification only reads entries written during the current capture.
module ook_pulse_repeat_detector_core
	import ookprd_pkg::*;
#(
	parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DUR_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [DUR_W-1:0]     duration,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           event_res,
	output logic                 receiving,
	output logic [MSG_LEN_W-1:0] message_length
);

	localparam int AW = $clog2(MAX_LEN);

	cfg_t             cfg_q;
	logic             valid_s1;
	logic [DUR_W-1:0] dur_s1;
	logic             advance;
	logic             out_valid_q;
	result_t          res_q;
	result_t          res_n;

	logic          sym_we;
	logic [AW-1:0] sym_waddr;
	logic          sym_wdata;
	logic [AW-1:0] sym_raddr;
	logic          sym_rd;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				REG_SHORT_ON:  cfg_q.short_on_time  <= cfg_data;
				REG_SHORT_OFF: cfg_q.short_off_time <= cfg_data;
				REG_LONG_ON:   cfg_q.long_on_time   <= cfg_data;
				REG_LONG_OFF:  cfg_q.long_off_time  <= cfg_data;
				REG_REST:      cfg_q.rest_time      <= cfg_data;
				REG_TOLERANCE: cfg_q.tolerance      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The input register moves on whenever the result register is free or
	// being emptied in this cycle.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			dur_s1 <= duration;
		end
	end

	ookprd_fsm #(
		.MAX_LEN(MAX_LEN)
	) u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.duration  (dur_s1),
		.cfg       (cfg_q),
		.sym_rd    (sym_rd),
		.sym_we    (sym_we),
		.sym_waddr (sym_waddr),
		.sym_wdata (sym_wdata),
		.sym_raddr (sym_raddr),
		.result    (res_n)
	);

	ookprd_ram #(
		.WIDTH(1),
		.DEPTH(MAX_LEN)
	) u_sym_ram (
		.clk   (clk),
		.we    (sym_we),
		.waddr (sym_waddr),
		.wdata (sym_wdata),
		.raddr (sym_raddr),
		.rdata (sym_rd)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign event_res      = res_q.event_res;
	assign receiving      = res_q.receiving;
	assign message_length = res_q.message_length;

endmodule

[rtl/ookprd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the captured symbol store.
module ookprd_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/ookprd_fsm.sv]
// Capture and verify sequencer of the OOK pulse repeat detector.
// Classifies one duration per advance, keeps the mode and counters and drives
// the symbol store. Depends on ookprd_pkg.
module ookprd_fsm
	import ookprd_pkg::*;
#(
	parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic [DUR_W-1:0]             duration,
	input  cfg_t                         cfg,
	input  logic                         sym_rd,
	output logic                         sym_we,
	output logic [$clog2(MAX_LEN)-1:0]   sym_waddr,
	output logic                         sym_wdata,
	output logic [$clog2(MAX_LEN)-1:0]   sym_raddr,
	output result_t                      result
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);

	mode_t         mode_q, mode_n;
	logic [CW-1:0] count_q, count_n;
	logic [CW-1:0] len_q, len_n;
	logic [AW-1:0] vidx_q, vidx_n;
	logic          conf_q, conf_n;
	event_t        ev;

	logic             rest_hit;
	logic             cap_on;
	logic             is_short;
	logic             is_long;
	logic             ver_on;
	logic [DUR_W-1:0] ver_nom;
	logic             ver_ok;
	logic             ver_last;
	logic [CW+MSG_LEN_W-1:0] len_wide;

	assign rest_hit = near_value(duration, cfg.rest_time, cfg.tolerance);
	assign cap_on   = ~count_q[0];
	assign is_short = near_value(duration, cap_on ? cfg.short_on_time : cfg.short_off_time,
			cfg.tolerance);
	assign is_long  = near_value(duration, cap_on ? cfg.long_on_time : cfg.long_off_time,
			cfg.tolerance);

	assign ver_on   = ~vidx_q[0];
	assign ver_nom  = sym_rd ? (ver_on ? cfg.long_on_time : cfg.long_off_time)
			: (ver_on ? cfg.short_on_time : cfg.short_off_time);
	assign ver_ok   = near_value(duration, ver_nom, cfg.tolerance);
	assign ver_last = ((CW'(vidx_q) + CW'(1)) == len_q);

	always_comb begin
		mode_n    = mode_q;
		count_n   = count_q;
		len_n     = len_q;
		vidx_n    = vidx_q;
		conf_n    = conf_q;
		ev        = EV_NONE;
		sym_we    = 1'b0;
		sym_wdata = is_long & ~is_short;
		case (mode_q)
			MODE_CAPTURE: begin
				if (rest_hit) begin
					if (count_q != '0) begin
						len_n  = count_q;
						vidx_n = '0;
						mode_n = MODE_VERIFY;
					end
				end else if ((!is_short && !is_long) || (count_q == CW'(MAX_LEN))) begin
					mode_n  = MODE_SEARCH;
					count_n = '0;
				end else begin
					sym_we  = advance;
					count_n = count_q + CW'(1);
				end
			end
			MODE_VERIFY: begin
				if (ver_ok) begin
					if (ver_last) begin
						if (!conf_q) begin
							conf_n = 1'b1;
							ev     = EV_BEGIN;
						end
						vidx_n = '0;
						mode_n = MODE_SKIP;
					end else begin
						vidx_n = vidx_q + AW'(1);
					end
				end else begin
					if (conf_q) begin
						conf_n = 1'b0;
						ev     = EV_STOP;
					end
					len_n   = '0;
					vidx_n  = '0;
					count_n = '0;
					mode_n  = rest_hit ? MODE_CAPTURE : MODE_SEARCH;
				end
			end
			MODE_SKIP: begin
				mode_n = MODE_VERIFY;
				vidx_n = '0;
			end
			default: begin
				len_n   = '0;
				vidx_n  = '0;
				count_n = '0;
				mode_n  = rest_hit ? MODE_CAPTURE : MODE_SEARCH;
			end
		endcase
	end

	assign sym_waddr = count_q[AW-1:0];
	// The read is issued at the edge that moves the index, so the symbol is
	// ready when the next item arrives.
	assign sym_raddr = advance ? vidx_n : vidx_q;

	assign len_wide = {{MSG_LEN_W{1'b0}}, len_n};
	assign result.event_res      = ev;
	assign result.receiving      = conf_n;
	assign result.message_length = ((mode_n == MODE_VERIFY) || (mode_n == MODE_SKIP))
			? len_wide[MSG_LEN_W-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SEARCH;
			count_q <= '0;
			len_q   <= '0;
			vidx_q  <= '0;
			conf_q  <= 1'b0;
		end else if (advance) begin
			mode_q  <= mode_n;
			count_q <= count_n;
			len_q   <= len_n;
			vidx_q  <= vidx_n;
			conf_q  <= conf_n;
		end
	end

endmodule
